/* rtl/array_linked_list_free_list_unit_assert.svh */
// Assertion macros used by the linked-list unit's top-level RTL file.
`ifndef ARRAY_LINKED_LIST_FREE_LIST_UNIT_ASSERT_SVH
`define ARRAY_LINKED_LIST_FREE_LIST_UNIT_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define ALFL_ASSERT_IMP(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("linked-list unit: implication failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define ALFL_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("linked-list unit: next-cycle implication failed");
`else
`define ALFL_ASSERT_IMP(label, clock, reset, ante, cons)
`define ALFL_ASSERT_NEXT(label, clock, reset, ante, cons)
`endif

`endif

/* rtl/alfl_pkg.sv */
// Package with the types, constants and codes of the linked-list unit.
package alfl_pkg;

  // Geometry of the list.
  localparam int CAPACITY     = 16;
  localparam int PAYLOAD_BITS = 64;
  localparam int IDX_W        = $clog2(CAPACITY);
  localparam int PTR_W        = $clog2(CAPACITY + 1);

  // Fixed field widths of the channels.
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;
  localparam int DATA_W   = 64;

  // The null link, also the head value of an empty list.
  localparam logic [PTR_W-1:0] NIL = PTR_W'(CAPACITY);

  // Operation codes.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_READ   = 2'd2
  } func_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;       // take a new item from the request channel
    logic ins;         // insert at head
    logic rm_head;     // check the head against the target slot
    logic rm_walk;     // one step of the search walk
    logic rm_unlink;   // bypass the target in its predecessor's link
    logic rm_free;     // push the target onto the free list
    logic rd_issue;    // start the payload read
    logic rd_capture;  // take the payload read data
    logic not_found;   // mark the remove as failed
    logic load_out;    // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    func_t func;       // operation of the item in hand
    logic  head_null;  // the list is empty
    logic  head_hit;   // the head is the target slot
    logic  link_null;  // the link just read is null
    logic  link_hit;   // the link just read is the target slot
    logic  steps_done; // the walk has used its full step budget
  } sts_t;

endpackage

/* rtl/alfl_if.sv */
// Request and response channel interfaces of the linked-list unit.
interface alfl_req_if;
  import alfl_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [IDX_W-1:0]  node_index;
  logic [DATA_W-1:0] payload;

  modport source (output valid, func, node_index, payload, input ready);
  modport sink (input valid, func, node_index, payload, output ready);
endinterface

interface alfl_rsp_if;
  import alfl_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    slot;
  logic [DATA_W-1:0]   read_data;
  logic [PTR_W-1:0]    count;
  logic [PTR_W-1:0]    first_node;

  modport source (output valid, status, slot, read_data, count, first_node, input ready);
  modport sink (input valid, status, slot, read_data, count, first_node, output ready);
endinterface

/* rtl/alfl_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module alfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/alfl_datapath.sv */
// Datapath: link table, payload store, list pointers and the result register.
module alfl_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  alfl_pkg::cmd_t              cmd,
  output alfl_pkg::sts_t              sts,
  input  logic [alfl_pkg::FUNC_W-1:0] req_func,
  input  logic [alfl_pkg::IDX_W-1:0]  req_node_index,
  input  logic [alfl_pkg::DATA_W-1:0] req_payload,
  output logic [alfl_pkg::STATUS_W-1:0] rsp_status,
  output logic [alfl_pkg::IDX_W-1:0]  rsp_slot,
  output logic [alfl_pkg::DATA_W-1:0] rsp_read_data,
  output logic [alfl_pkg::PTR_W-1:0]  rsp_count,
  output logic [alfl_pkg::PTR_W-1:0]  rsp_first_node
);
  import alfl_pkg::*;

  // List state.
  logic [PTR_W-1:0] link_table [CAPACITY];
  logic [CAPACITY-1:0] pay_valid;
  logic [PTR_W-1:0] head_ptr;
  logic [PTR_W-1:0] free_ptr;
  logic [PTR_W-1:0] node_count;

  // Item in hand and walk state.
  func_t             func_r;
  logic [IDX_W-1:0]  idx_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic [IDX_W-1:0]  cur;
  logic [PTR_W-1:0]  steps;

  // Result being built.
  status_t           status_r;
  logic [IDX_W-1:0]  slot_r;
  logic [DATA_W-1:0] rdata_r;

  // Link table access.
  logic [IDX_W-1:0]  link_raddr;
  logic [PTR_W-1:0]  link_raw;
  logic [PTR_W-1:0]  link_val;
  logic              link_we;
  logic [IDX_W-1:0]  link_waddr;
  logic [PTR_W-1:0]  link_wdata;

  // Payload store access.
  logic              ins_ok;
  logic [PAYLOAD_BITS-1:0] ram_q;

  // One link read a cycle; out-of-range links read as null.
  always_comb begin
    priority if (cmd.ins) begin
      link_raddr = free_ptr[IDX_W-1:0];
    end else if (cmd.rm_walk) begin
      link_raddr = cur;
    end else begin
      link_raddr = idx_r;
    end
  end

  assign link_raw = link_table[link_raddr];
  assign link_val = (link_raw >= NIL) ? NIL : link_raw;

  assign ins_ok = cmd.ins && (free_ptr != NIL);

  // One link write a cycle.
  always_comb begin
    link_we    = 1'b0;
    link_waddr = idx_r;
    link_wdata = free_ptr;
    priority if (ins_ok) begin
      link_we    = 1'b1;
      link_waddr = free_ptr[IDX_W-1:0];
      link_wdata = head_ptr;
    end else if (cmd.rm_unlink) begin
      link_we    = 1'b1;
      link_waddr = cur;
      link_wdata = link_val;
    end else if (cmd.rm_free) begin
      link_we    = 1'b1;
      link_waddr = idx_r;
      link_wdata = free_ptr;
    end
  end

  // Link table: reset threads every slot into the free list.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CAPACITY; i++) begin
        link_table[i] <= PTR_W'(i + 1);
      end
    end else if (link_we) begin
      link_table[link_waddr] <= link_wdata;
    end
  end

  // Payload store; a slot never written reads as zero.
  alfl_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (CAPACITY)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ins_ok),
    .waddr (free_ptr[IDX_W-1:0]),
    .wdata (pay_r),
    .re    (cmd.rd_issue),
    .raddr (idx_r),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pay_valid <= '0;
    end else if (ins_ok) begin
      pay_valid[free_ptr[IDX_W-1:0]] <= 1'b1;
    end
  end

  // Head, free pointer and node count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr   <= NIL;
      free_ptr   <= '0;
      node_count <= '0;
    end else begin
      priority if (ins_ok) begin
        free_ptr <= link_val;
        head_ptr <= free_ptr;
        if (node_count < NIL) begin
          node_count <= node_count + PTR_W'(1);
        end
      end else if (cmd.rm_head && sts.head_hit) begin
        head_ptr <= link_val;
      end else if (cmd.rm_free) begin
        free_ptr <= PTR_W'(idx_r);
        if (node_count != '0) begin
          node_count <= node_count - PTR_W'(1);
        end
      end
    end
  end

  // Item registers and the search walk.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r <= func_t'(req_func);
      idx_r  <= req_node_index;
      pay_r  <= req_payload[PAYLOAD_BITS-1:0];
    end
    if (cmd.rm_head) begin
      cur   <= head_ptr[IDX_W-1:0];
      steps <= '0;
    end else if (cmd.rm_walk && !sts.link_null && !sts.link_hit) begin
      cur   <= link_val[IDX_W-1:0];
      steps <= steps + PTR_W'(1);
    end
  end

  // Result fields of the item in hand.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      status_r <= ST_OK;
      slot_r   <= req_node_index;
      rdata_r  <= '0;
    end else if (cmd.ins) begin
      if (ins_ok) begin
        slot_r <= free_ptr[IDX_W-1:0];
      end else begin
        status_r <= ST_FULL;
        slot_r   <= '0;
      end
    end else if (cmd.not_found) begin
      status_r <= ST_NOT_FOUND;
    end else if (cmd.rd_capture) begin
      rdata_r <= pay_valid[idx_r] ? DATA_W'(ram_q) : '0;
    end
  end

  // Result register towards the response channel.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp_status     <= status_r;
      rsp_slot       <= slot_r;
      rsp_read_data  <= rdata_r;
      rsp_count      <= node_count;
      rsp_first_node <= head_ptr;
    end
  end

  // Status for the controller.
  assign sts.func       = func_r;
  assign sts.head_null  = (head_ptr == NIL);
  assign sts.head_hit   = (head_ptr == PTR_W'(idx_r));
  assign sts.link_null  = (link_val == NIL);
  assign sts.link_hit   = (link_val == PTR_W'(idx_r));
  assign sts.steps_done = (steps == NIL);

endmodule

/* rtl/alfl_ctrl.sv */
// Controller: sequences each operation and owns both channel handshakes.
module alfl_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  input  alfl_pkg::sts_t sts,
  output alfl_pkg::cmd_t cmd
);
  import alfl_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE       = 10'b00_0000_0001,
    S_DISPATCH   = 10'b00_0000_0010,
    S_INS        = 10'b00_0000_0100,
    S_RD_ISSUE   = 10'b00_0000_1000,
    S_RD_CAPTURE = 10'b00_0001_0000,
    S_RM_HEAD    = 10'b00_0010_0000,
    S_RM_WALK    = 10'b00_0100_0000,
    S_RM_UNLINK  = 10'b00_1000_0000,
    S_RM_FREE    = 10'b01_0000_0000,
    S_DONE       = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.func)
          FUNC_INSERT: state_next = S_INS;
          FUNC_REMOVE: state_next = S_RM_HEAD;
          FUNC_READ:   state_next = S_RD_ISSUE;
          default:     state_next = S_DONE;
        endcase
      end
      S_INS: begin
        cmd.ins    = 1'b1;
        state_next = S_DONE;
      end
      S_RD_ISSUE: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_RD_CAPTURE;
      end
      S_RD_CAPTURE: begin
        cmd.rd_capture = 1'b1;
        state_next     = S_DONE;
      end
      S_RM_HEAD: begin
        cmd.rm_head = 1'b1;
        priority if (sts.head_null) begin
          cmd.not_found = 1'b1;
          state_next    = S_DONE;
        end else if (sts.head_hit) begin
          state_next = S_RM_FREE;
        end else begin
          state_next = S_RM_WALK;
        end
      end
      S_RM_WALK: begin
        cmd.rm_walk = 1'b1;
        priority if (sts.steps_done || sts.link_null) begin
          cmd.not_found = 1'b1;
          state_next    = S_DONE;
        end else if (sts.link_hit) begin
          state_next = S_RM_UNLINK;
        end
      end
      S_RM_UNLINK: begin
        cmd.rm_unlink = 1'b1;
        state_next    = S_RM_FREE;
      end
      S_RM_FREE: begin
        cmd.rm_free = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result valid flag: set on load, cleared when the item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

/* rtl/array_linked_list_free_list_unit.sv */
// Fixed-capacity singly linked list of 16 slots whose free slots form a second list in the same
// link table. Insert takes the first free slot and pushes it at the head, remove searches the
// list from the head and returns the slot to the free list, read returns a slot's payload, and
// every result carries the node count and the head. One item is in work at a time. A remove on
// an empty list ends at the head check, a remove whose target is the head goes straight to
// freeing it, and any other remove walks the list until it finds the target, meets a null link
// or uses up its step budget. The search walk reads one link-table entry per cycle. A new item
// is accepted in the cycle after its predecessor's result is registered, even while that result
// still waits to be taken. No clearing pass is needed after reset.
module array_linked_list_free_list_unit (
  input logic      clk,
  input logic      rst,
  alfl_req_if.sink req,
  alfl_rsp_if.source rsp
);
  import alfl_pkg::*;

  `include "array_linked_list_free_list_unit_assert.svh"

  cmd_t cmd;
  sts_t sts;

  // Sequencing.
  alfl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // List storage and result register.
  alfl_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .req_func       (req.func),
    .req_node_index (req.node_index),
    .req_payload    (req.payload),
    .rsp_status     (rsp.status),
    .rsp_slot       (rsp.slot),
    .rsp_read_data  (rsp.read_data),
    .rsp_count      (rsp.count),
    .rsp_first_node (rsp.first_node)
  );

  // An empty list and a null head always go together.
  `ALFL_ASSERT_IMP(a_empty_head, clk, rst, rsp.valid, (rsp.count == '0) == (rsp.first_node == NIL))
  // A full insert is reported only with every slot in use.
  `ALFL_ASSERT_IMP(a_full_count, clk, rst, rsp.valid && (rsp.status == ST_FULL), rsp.count == NIL)
  // Once an item is accepted no other is taken until it is done.
  `ALFL_ASSERT_NEXT(a_one_item, clk, rst, req.valid && req.ready, !req.ready)

endmodule
